>>> rtl/smm_pkg.sv
// smm_pkg: shared constants, action codes and types for the square matrix multiply
// used by smm_store and square_matrix_multiply; no dependencies
`timescale 1ns / 1ps

package smm_pkg;

  localparam int MATRIX_SIZE = 16;
  localparam int IDX_W       = $clog2(MATRIX_SIZE);
  localparam int CELLS       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = 36;

  localparam logic [1:0] ACT_WRITE_A = 2'd0;
  localparam logic [1:0] ACT_WRITE_B = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  // write request into the element store
  typedef struct packed {
    logic                     a_we;
    logic                     b_we;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } smm_wr_t;

endpackage

>>> rtl/smm_store.sv
// smm_store: element memories for matrix A and matrix B, one write and one
// registered read per matrix per cycle; depends on smm_pkg
`timescale 1ns / 1ps

module smm_store
  import smm_pkg::*;
(
  input  logic                     clk,
  input  smm_wr_t                  wr,
  input  logic [ADDR_W-1:0]        rd_addr_a,
  input  logic [ADDR_W-1:0]        rd_addr_b,
  output logic signed [ELEM_W-1:0] rd_data_a,
  output logic signed [ELEM_W-1:0] rd_data_b
);

  logic signed [ELEM_W-1:0] mem_a [CELLS];
  logic signed [ELEM_W-1:0] mem_b [CELLS];

  always_ff @(posedge clk) begin
    if (wr.a_we) begin
      mem_a[wr.addr] <= wr.data;
    end
    rd_data_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr.b_we) begin
      mem_b[wr.addr] <= wr.data;
    end
    rd_data_b <= mem_b[rd_addr_b];
  end

endmodule

>>> rtl/square_matrix_multiply.sv
// square_matrix_multiply: sequencer, multiply-accumulate and result register
// depends on smm_pkg and smm_store
//
// usage:
//   input channel (in_valid / in_stall) carries action, row_index, col_index and
//   element_value. action write A / write B stores one Q1.15 element, and the
//   unused action code is taken and dropped.
//   a query item walks k = 0 .. 15, reading A[row][k] and B[k][col] from the two
//   element memories (one read per memory per cycle), multiplying in a register
//   stage and adding into a 36-bit accumulator.
//   a query holds in_stall high from when it is taken until its result is loaded: the
//   walk reads through the single read port of each memory, then the read, multiply and
//   accumulate registers drain and the result register loads; one query at a time.
//   output channel (out_valid / out_stall) gives result_row, result_col and
//   product_sum. the result register holds while out_stall is high; loads are
//   still taken then, and a following query waits before its result is loaded.
//   in_stall is high while a query is being worked on.
//   reset clears the sequencer and the output valid; element contents are
//   undefined until written.
`timescale 1ns / 1ps

module square_matrix_multiply
  import smm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [ELEM_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         result_row,
  output logic [IDX_W-1:0]         result_col,
  output logic signed [SUM_W-1:0]  product_sum
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]               state;
  logic [IDX_W-1:0]         k_cnt;
  logic [IDX_W-1:0]         qry_row;
  logic [IDX_W-1:0]         qry_col;
  logic                     rd_vld;
  logic                     mul_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  logic                     in_acc;
  logic                     qry_start;
  logic                     out_load;
  smm_wr_t                  wr;
  logic [ADDR_W-1:0]        rd_addr_a;
  logic [ADDR_W-1:0]        rd_addr_b;
  logic signed [ELEM_W-1:0] rd_data_a;
  logic signed [ELEM_W-1:0] rd_data_b;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign qry_start = in_acc && (action == ACT_QUERY);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    wr.a_we = in_acc && (action == ACT_WRITE_A);
    wr.b_we = in_acc && (action == ACT_WRITE_B);
    wr.addr = {row_index, col_index};
    wr.data = element_value;
  end

  // a row walks along k, b column walks down k
  assign rd_addr_a = {qry_row, k_cnt};
  assign rd_addr_b = {k_cnt, qry_col};

  smm_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      k_cnt   <= '0;
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= (state == ST_RUN);
      mul_vld <= rd_vld;
      unique case (state)
        ST_IDLE: begin
          if (qry_start) begin
            state <= ST_RUN;
            k_cnt <= '0;
          end
        end
        ST_RUN: begin
          k_cnt <= k_cnt + 1'b1;
          if (k_cnt == IDX_W'(MATRIX_SIZE - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld && !mul_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // query coordinates, product and accumulator
  always_ff @(posedge clk) begin
    if (qry_start) begin
      qry_row <= row_index;
      qry_col <= col_index;
      acc     <= '0;
    end else if (mul_vld) begin
      acc <= acc + SUM_W'(prod);
    end
    if (rd_vld) begin
      prod <= rd_data_a * rd_data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_row  <= qry_row;
      result_col  <= qry_col;
      product_sum <= acc;
    end
  end

`ifndef ASSERT_OFF
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    mul_vld |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("multiply stage active outside a query walk");

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!rd_vld && !mul_vld))
    else $error("result loaded before accumulation finished");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    qry_start |=> (state == ST_RUN && k_cnt == '0))
    else $error("query did not start its walk at k zero");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (wr.a_we || wr.b_we) |-> (state == ST_IDLE))
    else $error("element write while a query is in progress");
`endif

endmodule

>>> bench/tb_square_matrix_multiply.sv
// tb_square_matrix_multiply: self-checking bench for the square matrix multiply,
// with a scoreboard class that keeps its own copy of A and B and predicts each dot product
// depends on smm_pkg and square_matrix_multiply
`timescale 1ns / 1ps

module tb_square_matrix_multiply;
  import smm_pkg::*;

  localparam logic [1:0]               ACT_UNUSED     = 2'd3;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN       = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX       = 16'sh7fff;
  localparam int                       TOTAL_ITEMS    = 1850;
  localparam int                       QUIET_ITEMS    = 200;
  localparam int                       HOLD_CYCLES    = 300;
  localparam int                       DRAIN_CYCLES   = 40;
  localparam int                       WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] dot_sum;
  } product_t;

  class product_scoreboard;
    shortint  mat_a[CELLS];
    shortint  mat_b[CELLS];
    product_t pending_products[$];
    int       errors;
    int       loads;
    int       queries;
    int       dropped;

    function logic signed [SUM_W-1:0] dot_product(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
      longint acc;
      acc = 0;
      for (int k = 0; k < MATRIX_SIZE; k++)
        acc += longint'(mat_a[r * MATRIX_SIZE + k]) * longint'(mat_b[k * MATRIX_SIZE + c]);
      return acc[SUM_W-1:0];
    endfunction

    function void note_item(logic [1:0] act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                            logic signed [ELEM_W-1:0] v);
      int       addr;
      product_t p;
      addr = r * MATRIX_SIZE + c;
      case (act)
        ACT_WRITE_A: begin
          mat_a[addr] = v;
          loads++;
        end
        ACT_WRITE_B: begin
          mat_b[addr] = v;
          loads++;
        end
        ACT_QUERY: begin
          p.row     = r;
          p.col     = c;
          p.dot_sum = dot_product(r, c);
          pending_products.push_back(p);
          queries++;
        end
        default: dropped++;
      endcase
    endfunction

    function void check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                               logic signed [SUM_W-1:0] s);
      product_t p;
      if (pending_products.size() == 0) begin
        $error("unexpected result: row %0d col %0d product_sum %0d", r, c, s);
        errors++;
        return;
      end
      p = pending_products.pop_front();
      if (r !== p.row) begin
        $error("result_row: expected %0d, got %0d", p.row, r);
        errors++;
      end
      if (c !== p.col) begin
        $error("result_col: expected %0d, got %0d", p.col, c);
        errors++;
      end
      if (s !== p.dot_sum) begin
        $error("product_sum: expected %0d, got %0d", p.dot_sum, s);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               action;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] element_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [IDX_W-1:0]         result_row;
  logic [IDX_W-1:0]         result_col;
  logic signed [SUM_W-1:0]  product_sum;

  product_scoreboard sb;
  bit                gaps_on;
  bit                idle_on;
  bit                hold_request;
  int                items_sent;
  int                quiet_cycles;

  square_matrix_multiply i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_row    (result_row),
    .result_col    (result_col),
    .product_sum   (product_sum)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // offers one item and returns at the edge where it was taken
  task automatic send_item(input logic [1:0] act, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    row_index     <= r;
    col_index     <= c;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(act, r, c, v);
    items_sent++;
  endtask

  // fill both matrices; row 0 of A and column 0 of B at the minimum,
  // row 15 of A and column 15 of B at the maximum, the rest random
  task automatic load_matrices();
    logic signed [ELEM_W-1:0] va;
    logic signed [ELEM_W-1:0] vb;
    for (int r = 0; r < MATRIX_SIZE; r++) begin
      for (int c = 0; c < MATRIX_SIZE; c++) begin
        va = (r == 0) ? ELEM_MIN : (r == MATRIX_SIZE - 1) ? ELEM_MAX : pick_value();
        vb = (c == 0) ? ELEM_MIN : (c == MATRIX_SIZE - 1) ? ELEM_MAX : pick_value();
        send_item(ACT_WRITE_A, IDX_W'(r), IDX_W'(c), va);
        send_item(ACT_WRITE_B, IDX_W'(r), IDX_W'(c), vb);
      end
    end
  endtask

  // rewrite a whole row of A or column of B, then query products that use it
  task automatic rewrite_and_query();
    logic [IDX_W-1:0] idx;
    bit               on_a;
    idx  = IDX_W'($urandom_range(0, MATRIX_SIZE - 1));
    on_a = 1'($urandom_range(0, 1));
    for (int k = 0; k < MATRIX_SIZE; k++) begin
      if (on_a)
        send_item(ACT_WRITE_A, idx, IDX_W'(k), pick_value());
      else
        send_item(ACT_WRITE_B, IDX_W'(k), idx, pick_value());
    end
    repeat ($urandom_range(2, 5)) begin
      if (on_a)
        send_item(ACT_QUERY, idx, IDX_W'($urandom_range(0, 15)), ELEM_W'($urandom));
      else
        send_item(ACT_QUERY, IDX_W'($urandom_range(0, 15)), idx, ELEM_W'($urandom));
    end
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      send_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    else if (pick < 30)
      send_item(ACT_WRITE_A, IDX_W'($urandom), IDX_W'($urandom), pick_value());
    else if (pick < 57)
      send_item(ACT_WRITE_B, IDX_W'($urandom), IDX_W'($urandom), pick_value());
    else
      send_item(ACT_QUERY, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
  endtask

  // receiver side: random hold-off bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(result_row, result_col, product_sum);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_square_matrix_multiply: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_WRITE_A;
    row_index     = '0;
    col_index     = '0;
    element_value = '0;
    gaps_on       = 1'b1;
    idle_on       = 1'b1;
    hold_request  = 1'b0;
    items_sent    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // unused action code at the field extremes, nothing loaded yet
    send_item(ACT_UNUSED, 4'd15, 4'd15, ELEM_MIN);
    send_item(ACT_UNUSED, 4'd0, 4'd0, ELEM_MAX);
    load_matrices();

    // largest positive and most negative dot products
    send_item(ACT_QUERY, 4'd0, 4'd0, ELEM_MAX);
    send_item(ACT_QUERY, 4'd15, 4'd15, ELEM_MIN);
    send_item(ACT_QUERY, 4'd0, 4'd15, '0);
    send_item(ACT_QUERY, 4'd15, 4'd0, 16'sh5a5a);
    // writes right before a query that reads them, back-to-back queries
    send_item(ACT_WRITE_A, 4'd0, 4'd7, '0);
    send_item(ACT_QUERY, 4'd0, 4'd0, '0);
    send_item(ACT_WRITE_B, 4'd7, 4'd0, ELEM_MAX);
    send_item(ACT_QUERY, 4'd0, 4'd0, '0);
    send_item(ACT_QUERY, 4'd0, 4'd0, ELEM_MIN);
    send_item(ACT_UNUSED, 4'd0, 4'd0, '0);
    send_item(ACT_QUERY, 4'd15, 4'd15, '0);

    // long receiver hold while queries keep coming, so the input backs up
    hold_request = 1'b1;
    repeat (12) send_item(ACT_QUERY, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
        gaps_on = 1'b0;
        idle_on = 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        gaps_on = $urandom_range(0, 3) != 0;
        idle_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 24) == 0)
        rewrite_and_query();
      else
        random_item();
    end
    in_valid <= 1'b0;

    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_square_matrix_multiply: %0d items sent: %0d element loads, %0d products",
             items_sent, sb.loads, sb.queries);
    $display("tb_square_matrix_multiply: %0d unused-code items dropped, %0d mismatches",
             sb.dropped, sb.errors);
    if (sb.errors == 0)
      $display("tb_square_matrix_multiply: done, clean");
    else
      $display("tb_square_matrix_multiply: done, errors");
    $finish;
  end

endmodule
